// ===== rtl/core/iougba_pkg.sv =====
// Shared types and constants for the IoU greedy box association block.
// Used by the controller, the datapath, the overlap unit, the top level and the checker.
// No dependencies.
package iougba_pkg;

	localparam int DEF_MAX_DETECTIONS = 16;
	localparam int DEF_MAX_TRACKERS   = 16;
	localparam int RESULT_LIMIT       = 32;
	localparam int LIMIT_W            = $clog2(RESULT_LIMIT + 1);

	localparam logic [16:0] THRESH_RESET = 17'd19661;
	localparam logic [16:0] Q16_ONE      = 17'h10000;

	typedef enum logic [1:0] {
		ACT_DET = 2'd0,
		ACT_TRK = 2'd1,
		ACT_RUN = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_MATCH = 2'd0,
		KIND_UNDET = 2'd1,
		KIND_UNTRK = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic  load_det;
		logic  load_trk;
		logic  run_start;
		logic  box_rd;
		logic  iou_start;
		logic  tab_wr;
		logic  tab_rd;
		logic  best_clr;
		logic  take;
		logic  push;
		kind_t push_kind;
		logic  flush;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic iou_done;
		logic emit_ready;
		logic out_free;
		logic best_found;
		logic det_taken;
		logic trk_taken;
	} dp_stat_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ===== rtl/core/iougba_iou.sv =====
// Multi-cycle intersection-over-union unit for one pair of boxes, result in Q1.16.
// Depends on iougba_pkg.
module iougba_iou (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] box_a,
	input  logic [63:0] box_b,
	output logic        done,
	output logic [16:0] q
);
	import iougba_pkg::*;

	typedef enum logic [2:0] {
		I_IDLE,
		I_PROD,
		I_UNION,
		I_CHECK,
		I_DIV
	} iou_state_t;

	iou_state_t state_q;

	logic signed [15:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	logic signed [15:0] mn_x, mx_x, mn_y, mx_y;
	logic signed [16:0] w_c, h_c;

	logic        [15:0] w_q, h_q;
	logic signed [16:0] dxa_q, dya_q, dxb_q, dyb_q;
	logic        [31:0] inter_q;
	logic signed [33:0] area_a_q, area_b_q;
	logic signed [35:0] uni_q;
	logic        [35:0] rem_q, rem_sh;
	logic        [15:0] quo_q, quo_n;
	logic        [3:0]  cnt_q;
	logic               sub_ok;
	logic               done_q;
	logic        [16:0] q_q;

	assign {by1, bx1, by0, bx0} = box_b;
	assign {ay1, ax1, ay0, ax0} = box_a;

	// overlap extents
	always_comb begin
		mn_x = (ax1 < bx1) ? ax1 : bx1;
		mx_x = (ax0 > bx0) ? ax0 : bx0;
		mn_y = (ay1 < by1) ? ay1 : by1;
		mx_y = (ay0 > by0) ? ay0 : by0;
		w_c  = {mn_x[15], mn_x} - {mx_x[15], mx_x};
		h_c  = {mn_y[15], mn_y} - {mx_y[15], mx_y};
	end

	// one restoring division step
	always_comb begin
		rem_sh = {rem_q[34:0], 1'b0};
		sub_ok = rem_sh >= 36'(uni_q);
		quo_n  = {quo_q[14:0], sub_ok};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				I_IDLE: begin
					if (start) state_q <= I_PROD;
				end
				I_PROD:  state_q <= I_UNION;
				I_UNION: state_q <= I_CHECK;
				I_CHECK: begin
					if (uni_q <= 36'sd0 || $signed({4'b0, inter_q}) >= uni_q) begin
						done_q  <= 1'b1;
						state_q <= I_IDLE;
					end else begin
						cnt_q   <= '0;
						state_q <= I_DIV;
					end
				end
				I_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						done_q  <= 1'b1;
						state_q <= I_IDLE;
					end
				end
				default: state_q <= I_IDLE;
			endcase
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (state_q == I_IDLE && start) begin
			w_q   <= w_c[16] ? 16'd0 : w_c[15:0];
			h_q   <= h_c[16] ? 16'd0 : h_c[15:0];
			dxa_q <= {ax1[15], ax1} - {ax0[15], ax0};
			dya_q <= {ay1[15], ay1} - {ay0[15], ay0};
			dxb_q <= {bx1[15], bx1} - {bx0[15], bx0};
			dyb_q <= {by1[15], by1} - {by0[15], by0};
		end
		if (state_q == I_PROD) begin
			inter_q  <= w_q * h_q;
			area_a_q <= dxa_q * dya_q;
			area_b_q <= dxb_q * dyb_q;
		end
		if (state_q == I_UNION) begin
			uni_q <= 36'(area_a_q) + 36'(area_b_q) - $signed({4'b0, inter_q});
		end
		if (state_q == I_CHECK) begin
			rem_q <= {4'b0, inter_q};
			quo_q <= '0;
			if (uni_q <= 36'sd0) q_q <= '0;
			else                  q_q <= Q16_ONE;
		end
		if (state_q == I_DIV) begin
			rem_q <= sub_ok ? (rem_sh - 36'(uni_q)) : rem_sh;
			quo_q <= quo_n;
			q_q   <= {1'b0, quo_n};
		end
	end

	assign q    = q_q;
	assign done = done_q;

endmodule

// ===== rtl/core/iougba_dp.sv =====
// Datapath: box stores, overlap unit, overlap table, greedy best search, taken flags
// and the result stage. Depends on iougba_pkg and iougba_iou.
module iougba_dp #(
	parameter int MAX_DETECTIONS = iougba_pkg::DEF_MAX_DETECTIONS,
	parameter int MAX_TRACKERS   = iougba_pkg::DEF_MAX_TRACKERS,
	localparam int DIW = iougba_pkg::idx_w(MAX_DETECTIONS),
	localparam int TIW = iougba_pkg::idx_w(MAX_TRACKERS),
	localparam int DCW = $clog2(MAX_DETECTIONS + 1),
	localparam int TCW = $clog2(MAX_TRACKERS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [63:0]         box_in,
	input  logic                thr_we,
	input  logic [16:0]         thr_wdata,
	input  iougba_pkg::dp_cmd_t cmd,
	input  logic [DIW-1:0]      det_ptr,
	input  logic [TIW-1:0]      trk_ptr,
	output logic [DCW-1:0]      det_count,
	output logic [TCW-1:0]      trk_count,
	output iougba_pkg::dp_stat_t stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);
	import iougba_pkg::*;

	localparam int TAB_DEPTH = 2 ** (DIW + TIW);

	logic [63:0] det_mem [MAX_DETECTIONS];
	logic [63:0] trk_mem [MAX_TRACKERS];
	logic [16:0] tab_mem [TAB_DEPTH];

	logic [DCW-1:0] det_cnt_q;
	logic [TCW-1:0] trk_cnt_q;
	logic           dropped_q;
	logic [16:0]    thr_q;
	logic [63:0]    det_rd_q, trk_rd_q;
	logic           iou_done;
	logic [16:0]    iou_q;

	logic [MAX_DETECTIONS-1:0] det_taken_q;
	logic [MAX_TRACKERS-1:0]   trk_taken_q;

	logic [16:0]    tab_rd_s1;
	logic           rd_v_s1;
	logic [DIW-1:0] rd_d_s1;
	logic [TIW-1:0] rd_t_s1;
	logic           found_q;
	logic [DIW-1:0] best_d_q;
	logic [TIW-1:0] best_t_q;
	logic [16:0]    best_v_q;
	logic           hit;

	logic [LIMIT_W-1:0] emit_cnt_q;
	logic        pend_v_q;
	kind_t       pend_kind_q;
	logic [3:0]  pend_d_q, pend_t_q;
	logic [16:0] pend_ov_q;
	logic        pend_of_q;
	logic        out_v_q;
	kind_t       out_kind_q;
	logic [3:0]  out_d_q, out_t_q;
	logic [16:0] out_ov_q;
	logic        out_of_q, out_last_q;

	kind_t       new_kind;
	logic [3:0]  new_d, new_t;
	logic [16:0] new_ov;
	logic        out_free, push_ok, move_out, flush_out;

	iougba_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.iou_start),
		.box_a  (det_rd_q),
		.box_b  (trk_rd_q),
		.done   (iou_done),
		.q      (iou_q)
	);

	// box stores and table
	always_ff @(posedge clk) begin
		if (cmd.load_det && det_cnt_q < DCW'(MAX_DETECTIONS))
			det_mem[det_cnt_q[DIW-1:0]] <= box_in;
		if (cmd.load_trk && trk_cnt_q < TCW'(MAX_TRACKERS))
			trk_mem[trk_cnt_q[TIW-1:0]] <= box_in;
		if (cmd.box_rd) begin
			det_rd_q <= det_mem[det_ptr];
			trk_rd_q <= trk_mem[trk_ptr];
		end
		if (cmd.tab_wr) tab_mem[{det_ptr, trk_ptr}] <= iou_q;
		if (cmd.tab_rd) tab_rd_s1 <= tab_mem[{det_ptr, trk_ptr}];
		rd_d_s1 <= det_ptr;
		rd_t_s1 <= trk_ptr;
	end

	// candidate beats the best so far
	assign hit = rd_v_s1 && !det_taken_q[rd_d_s1] && !trk_taken_q[rd_t_s1] &&
		tab_rd_s1 >= thr_q && (!found_q || tab_rd_s1 > best_v_q);

	// counts, flags, threshold and best search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_cnt_q   <= '0;
			trk_cnt_q   <= '0;
			dropped_q   <= 1'b0;
			thr_q       <= THRESH_RESET;
			det_taken_q <= '0;
			trk_taken_q <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (thr_we) thr_q <= thr_wdata;
			if (cmd.load_det) begin
				if (det_cnt_q < DCW'(MAX_DETECTIONS)) det_cnt_q <= det_cnt_q + 1'b1;
				else                                   dropped_q <= 1'b1;
			end
			if (cmd.load_trk) begin
				if (trk_cnt_q < TCW'(MAX_TRACKERS)) trk_cnt_q <= trk_cnt_q + 1'b1;
				else                                 dropped_q <= 1'b1;
			end
			rd_v_s1 <= cmd.tab_rd;
			if (cmd.best_clr) found_q <= 1'b0;
			else if (hit)     found_q <= 1'b1;
			if (cmd.take) begin
				det_taken_q[best_d_q] <= 1'b1;
				trk_taken_q[best_t_q] <= 1'b1;
			end
			if (cmd.run_start || cmd.flush) begin
				det_taken_q <= '0;
				trk_taken_q <= '0;
			end
			if (cmd.flush) begin
				det_cnt_q <= '0;
				trk_cnt_q <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			best_d_q <= rd_d_s1;
			best_t_q <= rd_t_s1;
			best_v_q <= tab_rd_s1;
		end
	end

	// select the fields of a new result
	always_comb begin
		new_kind = cmd.push_kind;
		new_d    = '0;
		new_t    = '0;
		new_ov   = '0;
		case (cmd.push_kind)
			KIND_MATCH: begin
				new_d  = 4'(best_d_q);
				new_t  = 4'(best_t_q);
				new_ov = best_v_q;
			end
			KIND_UNDET: new_d = 4'(det_ptr);
			KIND_UNTRK: new_t = 4'(trk_ptr);
			default: ;
		endcase
	end

	assign out_free  = !out_v_q || m_tready;
	assign push_ok   = cmd.push && (emit_cnt_q < LIMIT_W'(RESULT_LIMIT));
	assign move_out  = push_ok && pend_v_q;
	assign flush_out = cmd.flush && pend_v_q;

	// pending result and output register: last is known once the next one shows up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (cmd.run_start) emit_cnt_q <= '0;
			if (push_ok) begin
				emit_cnt_q <= emit_cnt_q + 1'b1;
				pend_v_q   <= 1'b1;
			end
			if (move_out || flush_out) out_v_q <= 1'b1;
			if (flush_out) pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			pend_kind_q <= new_kind;
			pend_d_q    <= new_d;
			pend_t_q    <= new_t;
			pend_ov_q   <= new_ov;
			pend_of_q   <= dropped_q;
		end
		if (move_out || flush_out) begin
			out_kind_q <= pend_kind_q;
			out_d_q    <= pend_d_q;
			out_t_q    <= pend_t_q;
			out_ov_q   <= pend_ov_q;
			out_of_q   <= pend_of_q;
			out_last_q <= flush_out;
		end
	end

	assign det_count = det_cnt_q;
	assign trk_count = trk_cnt_q;

	always_comb begin
		stat.iou_done   = iou_done;
		stat.emit_ready = !pend_v_q || out_free;
		stat.out_free   = out_free;
		stat.best_found = found_q;
		stat.det_taken  = det_taken_q[det_ptr];
		stat.trk_taken  = trk_taken_q[trk_ptr];
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, out_of_q, out_ov_q, out_t_q, out_d_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/core/iougba_ctrl.sv =====
// Controller state machine: sequences loads, table fill, greedy picks and result emission.
// Depends on iougba_pkg.
module iougba_ctrl #(
	parameter int MAX_DETECTIONS = iougba_pkg::DEF_MAX_DETECTIONS,
	parameter int MAX_TRACKERS   = iougba_pkg::DEF_MAX_TRACKERS,
	localparam int DIW = iougba_pkg::idx_w(MAX_DETECTIONS),
	localparam int TIW = iougba_pkg::idx_w(MAX_TRACKERS),
	localparam int DCW = $clog2(MAX_DETECTIONS + 1),
	localparam int TCW = $clog2(MAX_TRACKERS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic [1:0]           action,
	output logic                 s_tready,
	input  logic [DCW-1:0]       det_count,
	input  logic [TCW-1:0]       trk_count,
	input  iougba_pkg::dp_stat_t stat,
	output iougba_pkg::dp_cmd_t  cmd,
	output logic [DIW-1:0]       det_ptr,
	output logic [TIW-1:0]       trk_ptr
);
	import iougba_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMPTY,
		ST_BOX_RD,
		ST_IOU_GO,
		ST_IOU_WAIT,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_UNDET,
		ST_UNTRK,
		ST_FLUSH
	} state_t;

	state_t         state_q;
	logic [DCW-1:0] i_q;
	logic [TCW-1:0] j_q;
	logic           accept;
	logic           last_j, last_i, i_end, j_end;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign det_ptr  = i_q[DIW-1:0];
	assign trk_ptr  = j_q[TIW-1:0];
	assign last_j   = (j_q == TCW'(trk_count - 1'b1));
	assign last_i   = (i_q == DCW'(det_count - 1'b1));
	assign i_end    = (i_q == det_count);
	assign j_end    = (j_q == trk_count);

	// decode commands
	always_comb begin
		cmd = '0;
		cmd.push_kind = KIND_MATCH;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_DET: cmd.load_det  = 1'b1;
						ACT_TRK: cmd.load_trk  = 1'b1;
						ACT_RUN: cmd.run_start = 1'b1;
						default: ;
					endcase
				end
			end
			ST_EMPTY: begin
				cmd.push      = stat.emit_ready;
				cmd.push_kind = KIND_NONE;
			end
			ST_BOX_RD:    cmd.box_rd    = 1'b1;
			ST_IOU_GO:    cmd.iou_start = 1'b1;
			ST_IOU_WAIT:  cmd.tab_wr    = stat.iou_done;
			ST_SCAN_INIT: cmd.best_clr  = 1'b1;
			ST_SCAN:      cmd.tab_rd    = 1'b1;
			ST_DECIDE: begin
				cmd.take = stat.best_found && stat.emit_ready;
				cmd.push = stat.best_found && stat.emit_ready;
			end
			ST_UNDET: begin
				cmd.push      = !i_end && !stat.det_taken && stat.emit_ready;
				cmd.push_kind = KIND_UNDET;
			end
			ST_UNTRK: begin
				cmd.push      = !j_end && !stat.trk_taken && stat.emit_ready;
				cmd.push_kind = KIND_UNTRK;
			end
			ST_FLUSH: cmd.flush = stat.out_free;
			default: ;
		endcase
	end

	// state and pair counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && action == ACT_RUN) begin
						i_q <= '0;
						j_q <= '0;
						if (det_count == '0 && trk_count == '0)      state_q <= ST_EMPTY;
						else if (det_count == '0 || trk_count == '0) state_q <= ST_UNDET;
						else                                          state_q <= ST_BOX_RD;
					end
				end
				ST_EMPTY: begin
					if (stat.emit_ready) state_q <= ST_FLUSH;
				end
				ST_BOX_RD: state_q <= ST_IOU_GO;
				ST_IOU_GO: state_q <= ST_IOU_WAIT;
				ST_IOU_WAIT: begin
					if (stat.iou_done) begin
						if (last_j) begin
							j_q <= '0;
							if (last_i) begin
								i_q     <= '0;
								state_q <= ST_SCAN_INIT;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= ST_BOX_RD;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_BOX_RD;
						end
					end
				end
				ST_SCAN_INIT: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (last_j) begin
						j_q <= '0;
						if (last_i) begin
							i_q     <= '0;
							state_q <= ST_SCAN_END;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_SCAN_END: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (stat.best_found) begin
						if (stat.emit_ready) state_q <= ST_SCAN_INIT;
					end else begin
						i_q     <= '0;
						state_q <= ST_UNDET;
					end
				end
				ST_UNDET: begin
					if (i_end) begin
						j_q     <= '0;
						state_q <= ST_UNTRK;
					end else if (stat.det_taken || stat.emit_ready) begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_UNTRK: begin
					if (j_end) begin
						state_q <= ST_FLUSH;
					end else if (stat.trk_taken || stat.emit_ready) begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/iou_greedy_box_association.sv =====
// IoU greedy box association. Load beats (one detection or tracker box each) are taken one
// per clock while the block is idle. When detections and trackers are both loaded, a run beat
// first fills the overlap table one pair at a time through a shared divider unit (D*T pairs),
// then makes each greedy pick with a full pass over the table, then walks detections and
// trackers once for the unmatched results; no new beat is taken until the last result has
// left the pending register. The output register lets the next result wait while the
// previous one is still being taken downstream.
module iou_greedy_box_association #(
	parameter int MAX_DETECTIONS = iougba_pkg::DEF_MAX_DETECTIONS,
	parameter int MAX_TRACKERS   = iougba_pkg::DEF_MAX_TRACKERS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // x_left, y_top, x_right, y_bottom
	input  logic [1:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // det_index, trk_index, overlap, overflow
	output logic [1:0]  m_tuser,  // kind
	output logic        m_tlast,
	input  logic        iou_threshold_we,
	input  logic [16:0] iou_threshold_wdata
);
	import iougba_pkg::*;

	localparam int DIW = idx_w(MAX_DETECTIONS);
	localparam int TIW = idx_w(MAX_TRACKERS);
	localparam int DCW = $clog2(MAX_DETECTIONS + 1);
	localparam int TCW = $clog2(MAX_TRACKERS + 1);

	dp_cmd_t        cmd;
	dp_stat_t       stat;
	logic [DIW-1:0] det_ptr;
	logic [TIW-1:0] trk_ptr;
	logic [DCW-1:0] det_count;
	logic [TCW-1:0] trk_count;

	iougba_ctrl #(
		.MAX_DETECTIONS (MAX_DETECTIONS),
		.MAX_TRACKERS   (MAX_TRACKERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.action    (s_tuser),
		.s_tready  (s_tready),
		.det_count (det_count),
		.trk_count (trk_count),
		.stat      (stat),
		.cmd       (cmd),
		.det_ptr   (det_ptr),
		.trk_ptr   (trk_ptr)
	);

	iougba_dp #(
		.MAX_DETECTIONS (MAX_DETECTIONS),
		.MAX_TRACKERS   (MAX_TRACKERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.box_in    (s_tdata),
		.thr_we    (iou_threshold_we),
		.thr_wdata (iou_threshold_wdata),
		.cmd       (cmd),
		.det_ptr   (det_ptr),
		.trk_ptr   (trk_ptr),
		.det_count (det_count),
		.trk_count (trk_count),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== rtl/core/iougba_checker.sv =====
// Port-level checks for the IoU greedy box association block, bound to the top level.
// Depends on iougba_pkg and iou_greedy_box_association.
module iougba_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import iougba_pkg::*;

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result beat changed");

	// a run beat closes the input until the run is over
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_RUN |=> !s_tready)
		else $error("input open right after a run beat");

	// nothing loaded is the only result of its run
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NONE |-> m_tlast)
		else $error("empty-run result without last");

	// only a match carries an overlap
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_MATCH |-> m_tdata[24:8] == 17'd0)
		else $error("overlap on a non-match result");

endmodule

bind iou_greedy_box_association iougba_port_checks u_checker (.*);
